// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ----- src/chm_pkg.sv -----
// types, constants and helpers for the chained hash map
// no dependencies
`default_nettype none
package chm_pkg;
  localparam int MAX_BUCKETS = 16;
  localparam int POOL_NODES = 32;
  localparam int KEY_BYTES = 8;
  localparam int NODE_W = $clog2(POOL_NODES) + 1;
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int SUM_W = 11;
  localparam logic [NODE_W-1:0] EMPTY_MARK = NODE_W'(POOL_NODES);

  localparam logic [1:0] REQ_PUT = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0] req_type;
    logic [63:0] key;
    logic [31:0] value;
    logic [BKT_W-1:0] bucket;
  } job_t;
endpackage
`default_nettype wire

// ----- src/chm_if.sv -----
// valid/ready channel interfaces for requests, results and configuration
// depends on nothing
`default_nettype none
interface chm_req_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [63:0] key;
  logic signed [31:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

interface chm_rsp_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [2:0] status;
  logic signed [31:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

interface chm_cfg_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/chm_front.sv -----
// front end: key canonicalisation, byte-sum hash and bucket reduction
// depends on chm_pkg
`default_nettype none
module chm_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [63:0] key,
  input  wire logic [31:0] value,
  input  wire logic [4:0] bucket_count,
  output logic job_valid,
  input  wire logic job_ready,
  output chm_pkg::job_t job
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD = 3'b010,
    F_OUT = 3'b100
  } fstate_t;

  fstate_t state;
  logic [1:0] req_r;
  logic [63:0] key_r;
  logic [31:0] value_r;
  logic [chm_pkg::SUM_W-1:0] rem;
  logic [4:0] modulus;
  logic [63:0] canon;
  logic [chm_pkg::SUM_W-1:0] sum;
  logic stop;

  // cut the key at the first zero byte and sum the kept bytes
  always_comb begin
    canon = '0;
    sum = '0;
    stop = 1'b0;
    for (int i = 0; i < chm_pkg::KEY_BYTES; i++) begin
      if (key[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) begin
        canon[8*i +: 8] = key[8*i +: 8];
        sum = sum + chm_pkg::SUM_W'(key[8*i +: 8]);
      end
    end
  end

  always_comb begin
    if (bucket_count == 5'd0) modulus = 5'd1;
    else if (bucket_count > 5'(chm_pkg::MAX_BUCKETS)) modulus = 5'(chm_pkg::MAX_BUCKETS);
    else modulus = bucket_count;
  end

  assign in_ready = (state == F_IDLE);
  assign job_valid = (state == F_OUT);
  assign job.req_type = req_r;
  assign job.key = key_r;
  assign job.value = value_r;
  assign job.bucket = rem[chm_pkg::BKT_W-1:0];

  // repeated subtraction: sum is at most 2040, one modulus step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            req_r <= req_type;
            key_r <= canon;
            value_r <= value;
            rem <= sum;
            state <= F_MOD;
          end
        end
        F_MOD: begin
          if (rem >= chm_pkg::SUM_W'(modulus)) rem <= rem - chm_pkg::SUM_W'(modulus);
          else state <= F_OUT;
        end
        F_OUT: begin
          if (job_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_bucket_range, clk, rst, state == F_OUT, rem < chm_pkg::SUM_W'(chm_pkg::MAX_BUCKETS), "bucket out of range")
endmodule
`default_nettype wire

// ----- src/chm_queue.sv -----
// two-entry job queue between front and back
// depends on chm_pkg
`default_nettype none
module chm_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic wr_ready,
  input  wire chm_pkg::job_t wr_job,
  output logic rd_valid,
  input  wire logic rd_ready,
  output chm_pkg::job_t rd_job
);
  chm_pkg::job_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = slots[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  `include "assert_macros.svh"
  `CHK_ALWAYS(a_count_max, clk, rst, count <= 2'd2, "queue overflow")
endmodule
`default_nettype wire

// ----- src/chm_back.sv -----
// back end: chain walk and table update over the node pool
// depends on chm_pkg
`default_nettype none
module chm_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire chm_pkg::job_t job,
  output logic rsp_valid,
  input  wire logic rsp_ready,
  output logic [2:0] status,
  output logic [31:0] value_out
);
  localparam int NI = chm_pkg::NODE_W - 1;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_WALK = 5'b00010,
    B_RD = 5'b00100,
    B_ACT = 5'b01000,
    B_OUT = 5'b10000
  } bstate_t;

  bstate_t state;
  chm_pkg::job_t job_r;
  logic [chm_pkg::NODE_W-1:0] heads [chm_pkg::MAX_BUCKETS];
  logic [chm_pkg::NODE_W-1:0] links [chm_pkg::POOL_NODES];
  logic [63:0] node_keys [chm_pkg::POOL_NODES];
  logic [31:0] node_values [chm_pkg::POOL_NODES];
  logic [chm_pkg::NODE_W-1:0] free_head;
  logic [chm_pkg::NODE_W-1:0] cur;
  logic [chm_pkg::NODE_W-1:0] prev;
  logic [chm_pkg::NODE_W-1:0] steps;
  logic [63:0] rd_key;
  logic [31:0] rd_val;
  logic [chm_pkg::NODE_W-1:0] rd_link;
  logic [chm_pkg::NODE_W-1:0] free_link;
  logic [NI-1:0] init_idx;
  logic initing;

  assign job_ready = (state == B_IDLE) && !initing;
  assign rsp_valid = (state == B_OUT);

  // registered reads of the node memories at the current node, and of the link at the free-list head
  always_ff @(posedge clk) begin
    rd_key <= node_keys[cur[NI-1:0]];
    rd_val <= node_values[cur[NI-1:0]];
    rd_link <= links[cur[NI-1:0]];
    free_link <= links[free_head[NI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      initing <= 1'b1;
      init_idx <= '0;
      free_head <= '0;
      for (int i = 0; i < chm_pkg::MAX_BUCKETS; i++) heads[i] <= chm_pkg::EMPTY_MARK;
    end else if (initing) begin
      // link pass: node i points to i+1, one node per cycle
      links[init_idx] <= chm_pkg::NODE_W'(init_idx) + 1'b1;
      init_idx <= init_idx + 1'b1;
      if (init_idx == NI'(chm_pkg::POOL_NODES - 1)) initing <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            cur <= heads[job.bucket];
            prev <= chm_pkg::EMPTY_MARK;
            steps <= '0;
            state <= B_WALK;
          end
        end
        B_WALK: begin
          if (cur[NI] || steps == chm_pkg::NODE_W'(chm_pkg::POOL_NODES)) begin
            if (!cur[NI]) cur <= chm_pkg::EMPTY_MARK;
            state <= B_ACT;
          end else begin
            state <= B_RD;
          end
        end
        B_RD: begin
          if (rd_key == job_r.key) begin
            state <= B_ACT;
          end else begin
            prev <= cur;
            cur <= rd_link;
            steps <= steps + 1'b1;
            state <= B_WALK;
          end
        end
        B_ACT: begin
          value_out <= '0;
          status <= chm_pkg::ST_NOT_FOUND;
          case (job_r.req_type)
            chm_pkg::REQ_PUT: begin
              if (!cur[NI]) begin
                node_values[cur[NI-1:0]] <= job_r.value;
                status <= chm_pkg::ST_UPDATED;
              end else if (free_head[NI]) begin
                status <= chm_pkg::ST_FULL;
              end else begin
                free_head <= free_link;
                node_keys[free_head[NI-1:0]] <= job_r.key;
                node_values[free_head[NI-1:0]] <= job_r.value;
                links[free_head[NI-1:0]] <= heads[job_r.bucket];
                heads[job_r.bucket] <= free_head;
                status <= chm_pkg::ST_INSERTED;
              end
            end
            chm_pkg::REQ_GET: begin
              if (!cur[NI]) begin
                status <= chm_pkg::ST_FOUND;
                value_out <= rd_val;
              end else begin
                value_out <= '1;
              end
            end
            chm_pkg::REQ_REMOVE: begin
              if (!cur[NI]) begin
                if (!prev[NI]) links[prev[NI-1:0]] <= rd_link;
                else heads[job_r.bucket] <= rd_link;
                links[cur[NI-1:0]] <= free_head;
                free_head <= cur;
                status <= chm_pkg::ST_REMOVED;
              end
            end
            default: ;
          endcase
          state <= B_OUT;
        end
        B_OUT: begin
          if (rsp_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_no_job_in_init, clk, rst, initing, !job_ready, "job taken during link pass")
  `CHK_IMPL(a_walk_bound, clk, rst, state == B_RD, steps < chm_pkg::NODE_W'(chm_pkg::POOL_NODES), "chain walk too long")
endmodule
`default_nettype wire

// ----- src/chained_hash_map_core.sv -----
// a request passes the front end's bucket reduction, the job queue and the back end's chain walk
// one request in the back end at a time; the chain walk (states B_WALK and B_RD per node) and the
// subtractive bucket reduction in the front end set the rate
// reset: synchronous; a link pass over the 32 pool nodes builds the free list, requests wait meanwhile
// top level: wires front end, job queue and back end; depends on chm_pkg and chm_if
`default_nettype none
module chained_hash_map_core (
  input wire logic clk,
  input wire logic rst,
  chm_req_if.sink req,
  chm_rsp_if.source rsp,
  chm_cfg_if.sink cfg
);
  logic [4:0] bucket_count;
  logic f_valid;
  logic f_ready;
  chm_pkg::job_t f_job;
  logic b_valid;
  logic b_ready;
  chm_pkg::job_t b_job;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= 5'd5;
    else if (cfg.valid) bucket_count <= cfg.data;
  end

  chm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .req_type(req.req_type), .key(req.key), .value(req.value),
    .bucket_count(bucket_count),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  chm_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  chm_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.status), .value_out(rsp.value_out)
  );
endmodule
`default_nettype wire
